// File: hdl/qbis_pkg.sv
// Shared types, constants and arithmetic helpers of the quadratic bulb iteration step.
package qbis_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int COEF_USED   = 27;
	localparam int ROOT_STAGES = 32;
	localparam int BR_LAT      = ROOT_STAGES + 7;
	localparam int ROT_LAT     = 2;
	localparam int TOTAL_LAT   = 1 + 2 * BR_LAT + ROT_LAT;

	typedef logic signed [31:0] fx_t;

	localparam fx_t FX_ONE = 32'sd1 <<< FRAC_BITS;
	localparam fx_t FX_TWO = FX_ONE <<< 1;
	localparam fx_t FX_MAX = 32'sh7fffffff;
	localparam fx_t FX_MIN = 32'sh80000000;
	localparam logic signed [65:0] W_MAX = 66'sd2147483647;
	localparam logic signed [65:0] W_MIN = -66'sd2147483648;

	typedef enum logic [1:0] {
		CFG_MODE,
		CFG_WINDOWS,
		CFG_COEF_INDEX,
		CFG_COEF_VALUE
	} cfg_idx_t;

	localparam int C_BR1       = 0;
	localparam int C_BR2       = 8;
	localparam int C_ROT       = 16;
	localparam int C_DE_SCALE  = 25;
	localparam int C_DE_OFFSET = 26;
	localparam int B_OFF       = 0;
	localparam int B_MUL       = 1;
	localparam int B_RATIO     = 4;
	localparam int B_ADD       = 5;

	localparam int M_ABS   = 0;
	localparam int M_ABS_X = 1;
	localparam int M_BR1   = 4;
	localparam int M_WIN1  = 5;
	localparam int M_BR2   = 6;
	localparam int M_WIN2  = 7;
	localparam int M_TWEAK = 8;

	typedef struct packed {
		fx_t         x_in;
		fx_t         y_in;
		fx_t         z_in;
		logic [31:0] de_in;
		logic [7:0]  iteration;
		fx_t         seed_x;
		fx_t         seed_y;
		fx_t         seed_z;
	} in_t;

	typedef struct packed {
		fx_t         x_out;
		fx_t         y_out;
		fx_t         z_out;
		logic [31:0] de_out;
		logic        overflow;
	} out_t;

	typedef struct packed {
		fx_t [2:0]   v;
		fx_t [2:0]   seed;
		logic [31:0] de;
		logic        ovf;
		logic        w1;
		logic        w2;
	} pt_t;

	function automatic logic signed [63:0] mul_fx(input fx_t a, input fx_t b);
		logic signed [63:0] r;
		r = a * b;
		return r;
	endfunction

	function automatic logic signed [65:0] fl_shift(input logic signed [63:0] p);
		return 66'(p >>> FRAC_BITS);
	endfunction

	function automatic fx_t sat_fx(input logic signed [65:0] a);
		fx_t r;
		if (a > W_MAX) r = FX_MAX;
		else if (a < W_MIN) r = FX_MIN;
		else r = a[31:0];
		return r;
	endfunction

	function automatic logic sat_ovf(input logic signed [65:0] a);
		return (a > W_MAX) || (a < W_MIN);
	endfunction

	function automatic fx_t coef_init(input int k);
		fx_t r;
		r = '0;
		if (k == 1 || k == 4 || k == 11 || k == 12 || k == 16 || k == 20 || k == 24 ||
				k == 25) r = FX_ONE;
		else if (k == 2 || k == 3 || k == 9 || k == 10) r = FX_TWO;
		return r;
	endfunction

endpackage

// File: hdl/qbis_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module qbis_sqrt #(
	parameter int W = 64
) (
	input  logic             clk,
	input  logic [W-1:0]     d,
	output logic [W/2-1:0]   q
);

	localparam int N = W / 2;

	logic [N-1:0] rem_s  [N+1];
	logic [N-1:0] root_s [N+1];
	logic [W-1:0] dat_s  [N+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign dat_s[0]  = d;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [N+1:0] r2;
		logic [N+1:0] trial;
		assign r2    = {rem_s[i], dat_s[i][W-1:W-2]};
		assign trial = {root_s[i], 2'b01};
		always_ff @(posedge clk) begin
			if (r2 >= trial) begin
				rem_s[i+1]  <= N'(r2 - trial);
				root_s[i+1] <= {root_s[i][N-2:0], 1'b1};
			end else begin
				rem_s[i+1]  <= N'(r2);
				root_s[i+1] <= {root_s[i][N-2:0], 1'b0};
			end
			dat_s[i+1] <= {dat_s[i][W-3:0], 2'b00};
		end
	end

	assign q = root_s[N];

endmodule

// File: hdl/qbis_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module qbis_div #(
	parameter int N  = 32,
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [N-1:0]  lo,
	input  logic [DW-1:0] dvs,
	output logic [N-1:0]  quot
);

	logic [DW-1:0] rem_s [N+1];
	logic [N-1:0]  lo_s  [N+1];
	logic [DW-1:0] dv_s  [N+1];
	logic [N-1:0]  q_s   [N+1];

	assign rem_s[0] = rem_in;
	assign lo_s[0]  = lo;
	assign dv_s[0]  = dvs;
	assign q_s[0]   = '0;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [DW:0] r2;
		assign r2 = {rem_s[i], lo_s[i][N-1]};
		always_ff @(posedge clk) begin
			if (r2 >= {1'b0, dv_s[i]}) begin
				rem_s[i+1] <= DW'(r2 - {1'b0, dv_s[i]});
				q_s[i+1]   <= {q_s[i][N-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= DW'(r2);
				q_s[i+1]   <= {q_s[i][N-2:0], 1'b0};
			end
			lo_s[i+1] <= {lo_s[i][N-2:0], 1'b0};
			dv_s[i+1] <= dv_s[i];
		end
	end

	assign quot = q_s[N];

endmodule

// File: hdl/qbis_branch.sv
// One triplex squaring branch with derivative update, as a fixed-latency pipeline.
module qbis_branch #(
	parameter int IP     = 0,
	parameter int IQ     = 1,
	parameter int IA     = 2,
	parameter bit SECOND = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  qbis_pkg::fx_t         off,
	input  qbis_pkg::fx_t [2:0]   mul,
	input  qbis_pkg::fx_t         ratio,
	input  qbis_pkg::fx_t [2:0]   addv,
	input  logic                  in_vld,
	input  qbis_pkg::pt_t         in_pt,
	output logic                  out_vld,
	output qbis_pkg::pt_t         out_pt
);

	localparam int N = qbis_pkg::ROOT_STAGES;

	typedef struct packed {
		qbis_pkg::pt_t p;
		qbis_pkg::fx_t temp;
		qbis_pkg::fx_t dpq;
		qbis_pkg::fx_t a1;
		qbis_pkg::fx_t q1;
		logic          eov;
		logic          lov;
		logic          big;
	} mid_t;

	// stage 1: squares and first products
	logic                vld_s1;
	qbis_pkg::pt_t       p_s1;
	logic [62:0]         sq_s1 [3];
	logic signed [63:0]  ma_s1;
	logic signed [63:0]  mq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_pt;
		for (int k = 0; k < 3; k++)
			sq_s1[k] <= 63'(qbis_pkg::mul_fx(in_pt.v[k], in_pt.v[k]));
		ma_s1 <= qbis_pkg::mul_fx(mul[IA], in_pt.v[IA]);
		mq_s1 <= qbis_pkg::mul_fx(mul[IQ], in_pt.v[IP]);
	end

	// stage 2: sums, temp, difference of squares
	logic                vld_s2;
	qbis_pkg::pt_t       p_s2;
	logic [63:0]         sum_s2;
	logic [62:0]         sa_s2;
	qbis_pkg::fx_t       temp_s2, dpq_s2, a1_s2, q1_s2;
	logic                eov_s2, lov_s2, big_s2;

	logic [63:0]         spq;
	logic signed [65:0]  tw;
	logic signed [63:0]  dw;
	qbis_pkg::fx_t       offw, temp_d;
	logic                win;

	always_comb begin
		win    = SECOND ? p_s1.w2 : p_s1.w1;
		offw   = win ? off : '0;
		spq    = 64'(sq_s1[IP]) + 64'(sq_s1[IQ]);
		tw     = $signed({2'b00, spq >> qbis_pkg::FRAC_BITS}) + 66'(offw);
		temp_d = qbis_pkg::sat_fx(tw);
		dw     = $signed({1'b0, sq_s1[IP]}) - $signed({1'b0, sq_s1[IQ]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2    <= p_s1;
		sum_s2  <= 64'(sq_s1[0]) + 64'(sq_s1[1]) + 64'(sq_s1[2]);
		sa_s2   <= sq_s1[IA];
		temp_s2 <= temp_d;
		eov_s2  <= qbis_pkg::sat_ovf(tw);
		dpq_s2  <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(dw));
		a1_s2   <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(ma_s1));
		q1_s2   <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(mq_s1));
		lov_s2  <= qbis_pkg::sat_ovf(qbis_pkg::fl_shift(dw)) |
			qbis_pkg::sat_ovf(qbis_pkg::fl_shift(ma_s1)) |
			qbis_pkg::sat_ovf(qbis_pkg::fl_shift(mq_s1));
		big_s2  <= {1'b0, sq_s1[IA][62:32]} >= $unsigned(temp_d);
	end

	// root and quotient units, with the item held alongside
	logic [31:0] len, sroot, quot;

	qbis_sqrt #(.W(64)) u_len (
		.clk (clk),
		.d   (sum_s2),
		.q   (len)
	);

	qbis_sqrt #(.W(64)) u_root (
		.clk (clk),
		.d   (64'($unsigned(temp_s2)) << qbis_pkg::FRAC_BITS),
		.q   (sroot)
	);

	qbis_div #(.N(32), .DW(31)) u_div (
		.clk    (clk),
		.rem_in (sa_s2[62:32]),
		.lo     (sa_s2[31:0]),
		.dvs    (temp_s2[30:0]),
		.quot   (quot)
	);

	mid_t mid_in;
	mid_t mid_s  [1:N];
	logic mvld_s [1:N];

	assign mid_in = '{p: p_s2, temp: temp_s2, dpq: dpq_s2, a1: a1_s2, q1: q1_s2,
		eov: eov_s2, lov: lov_s2, big: big_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N; k++) mvld_s[k] <= 1'b0;
		end else begin
			mvld_s[1] <= vld_s2;
			for (int k = 2; k <= N; k++) mvld_s[k] <= mvld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		mid_s[1] <= mid_in;
		for (int k = 2; k <= N; k++) mid_s[k] <= mid_s[k-1];
	end

	// stage 35: derivative product, t, second products
	mid_t                m;
	logic [30:0]         lenc;
	logic signed [65:0]  rw;

	assign m    = mid_s[N];
	assign lenc = len[31] ? 31'h7fffffff : len[30:0];
	assign rw   = 66'(ratio) - $signed({34'b0, quot});

	logic                vld_s35;
	qbis_pkg::pt_t       p_s35;
	qbis_pkg::fx_t       temp_s35, t_s35;
	logic                eov_s35, lov_s35;
	logic [62:0]         dep_s35;
	logic signed [63:0]  pa_s35, pp_s35, pq_s35;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s35 <= 1'b0;
		end else begin
			vld_s35 <= mvld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		p_s35    <= m.p;
		temp_s35 <= m.temp;
		eov_s35  <= m.eov | len[31];
		lov_s35  <= m.lov | m.big | qbis_pkg::sat_ovf(rw);
		t_s35    <= m.big ? qbis_pkg::FX_MIN : qbis_pkg::sat_fx(rw);
		dep_s35  <= 63'(m.p.de) * 63'(lenc);
		pa_s35   <= qbis_pkg::mul_fx(m.a1, $signed(sroot));
		pp_s35   <= qbis_pkg::mul_fx(mul[IP], m.dpq);
		pq_s35   <= qbis_pkg::mul_fx(m.q1, m.p.v[IQ]);
	end

	// stage 36: derivative finish, scale back products
	logic [40:0] dr;
	assign dr = 41'(dep_s35 >> (qbis_pkg::FRAC_BITS - 1)) + 41'd65536;

	logic                vld_s36;
	qbis_pkg::pt_t       p_s36;
	qbis_pkg::fx_t       temp_s36, t_s36, na0_s36, p1_s36, q2_s36;
	logic                eov_s36, lov_s36;
	logic [31:0]         de_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
		end else begin
			vld_s36 <= vld_s35;
		end
	end

	always_ff @(posedge clk) begin
		p_s36    <= p_s35;
		temp_s36 <= temp_s35;
		t_s36    <= t_s35;
		de_s36   <= (dr[40:32] != '0) ? 32'hffffffff : dr[31:0];
		eov_s36  <= eov_s35 | (dr[40:32] != '0);
		na0_s36  <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(pa_s35));
		p1_s36   <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(pp_s35));
		q2_s36   <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(pq_s35));
		lov_s36  <= lov_s35 | qbis_pkg::sat_ovf(qbis_pkg::fl_shift(pa_s35)) |
			qbis_pkg::sat_ovf(qbis_pkg::fl_shift(pp_s35)) |
			qbis_pkg::sat_ovf(qbis_pkg::fl_shift(pq_s35));
	end

	// stage 37: negate axial term, multiply by t
	logic signed [65:0] nw;
	assign nw = -66'(na0_s36);

	logic                vld_s37;
	qbis_pkg::pt_t       p_s37;
	qbis_pkg::fx_t       temp_s37, na_s37;
	logic                eov_s37, lov_s37;
	logic [31:0]         de_s37;
	logic signed [63:0]  pp2_s37, pq2_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s37 <= 1'b0;
		end else begin
			vld_s37 <= vld_s36;
		end
	end

	always_ff @(posedge clk) begin
		p_s37    <= p_s36;
		temp_s37 <= temp_s36;
		de_s37   <= de_s36;
		eov_s37  <= eov_s36;
		na_s37   <= qbis_pkg::sat_fx(nw);
		lov_s37  <= lov_s36 | qbis_pkg::sat_ovf(nw);
		pp2_s37  <= qbis_pkg::mul_fx(p1_s36, t_s36);
		pq2_s37  <= qbis_pkg::mul_fx(q2_s36, t_s36);
	end

	// stage 38: scale back, place per axis
	logic                vld_s38;
	qbis_pkg::pt_t       p_s38;
	qbis_pkg::fx_t       temp_s38;
	qbis_pkg::fx_t [2:0] n_s38;
	logic                eov_s38, lov_s38;
	logic [31:0]         de_s38;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s38 <= 1'b0;
		end else begin
			vld_s38 <= vld_s37;
		end
	end

	always_ff @(posedge clk) begin
		p_s38     <= p_s37;
		temp_s38  <= temp_s37;
		de_s38    <= de_s37;
		eov_s38   <= eov_s37;
		n_s38[IA] <= na_s37;
		n_s38[IP] <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(pp2_s37));
		n_s38[IQ] <= qbis_pkg::sat_fx(qbis_pkg::fl_shift(pq2_s37));
		lov_s38   <= lov_s37 | qbis_pkg::sat_ovf(qbis_pkg::fl_shift(pp2_s37)) |
			qbis_pkg::sat_ovf(qbis_pkg::fl_shift(pq2_s37));
	end

	// stage 39: add vector and pick the outcome
	qbis_pkg::pt_t       o;
	qbis_pkg::fx_t [2:0] nv;
	logic signed [65:0]  aw;
	logic                aov;

	always_comb begin
		aov = 1'b0;
		nv  = '0;
		aw  = '0;
		for (int k = 0; k < 3; k++) begin
			aw    = 66'(n_s38[k]) + 66'(addv[k]);
			nv[k] = qbis_pkg::sat_fx(aw);
			aov   = aov | qbis_pkg::sat_ovf(aw);
		end
		o = p_s38;
		if (en) begin
			o.de = de_s38;
			if (temp_s38 == '0) begin
				o.v   = p_s38.seed;
				o.ovf = p_s38.ovf | eov_s38;
			end else if (temp_s38[31]) begin
				o.v   = '0;
				o.ovf = p_s38.ovf | eov_s38;
			end else begin
				o.v   = nv;
				o.ovf = p_s38.ovf | eov_s38 | lov_s38 | aov;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s38;
		end
	end

	always_ff @(posedge clk) begin
		out_pt <= o;
	end

endmodule

// File: hdl/qbis_rot.sv
// Rotation by a 3x3 matrix and derivative tweak, two stages.
module qbis_rot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tweak,
	input  qbis_pkg::fx_t [8:0] rm,
	input  qbis_pkg::fx_t       scale,
	input  qbis_pkg::fx_t       offs,
	input  logic                in_vld,
	input  qbis_pkg::pt_t       in_pt,
	output logic                out_vld,
	output qbis_pkg::out_t      res
);

	logic                vld_s1;
	logic signed [63:0]  prod_s1 [9];
	logic signed [64:0]  dp_s1;
	logic [31:0]         de_s1;
	logic                ovf_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				prod_s1[3*i+j] <= qbis_pkg::mul_fx(rm[3*i+j], in_pt.v[j]);
		dp_s1  <= $signed({1'b0, in_pt.de}) * scale;
		de_s1  <= in_pt.de;
		ovf_s1 <= in_pt.ovf;
	end

	logic signed [65:0]  acc [3];
	logic signed [65:0]  dw;
	qbis_pkg::out_t      r;

	always_comb begin
		for (int i = 0; i < 3; i++)
			acc[i] = qbis_pkg::fl_shift(prod_s1[3*i]) + qbis_pkg::fl_shift(prod_s1[3*i+1]) +
				qbis_pkg::fl_shift(prod_s1[3*i+2]);
		dw = 66'(dp_s1 >>> qbis_pkg::FRAC_BITS) + 66'(offs >>> (qbis_pkg::FRAC_BITS - 16));
		r.x_out    = qbis_pkg::sat_fx(acc[0]);
		r.y_out    = qbis_pkg::sat_fx(acc[1]);
		r.z_out    = qbis_pkg::sat_fx(acc[2]);
		r.overflow = ovf_s1 | qbis_pkg::sat_ovf(acc[0]) | qbis_pkg::sat_ovf(acc[1]) |
			qbis_pkg::sat_ovf(acc[2]);
		r.de_out   = de_s1;
		if (tweak) begin
			if (dw[65]) begin
				r.de_out   = '0;
				r.overflow = 1'b1;
			end else if (dw > 66'sd4294967295) begin
				r.de_out   = 32'hffffffff;
				r.overflow = 1'b1;
			end else begin
				r.de_out = dw[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		res <= r;
	end

endmodule

// File: hdl/quadratic_bulb_iteration_step.sv
// Top level of the quadratic bulb iteration step: config store, abs stage, branches, rotation.
// Fully pipelined: a point is taken on every cycle with start high (busy is always low) and its
// result appears with a one-cycle done strobe. The latency is set by the two branch pipelines,
// each built around 32-stage square root and divider units, plus the input stage and the two-stage
// rotation. The receiver cannot stall; every beat must be taken when done is high. The user
// must write configuration via cfg_we/cfg_idx/cfg_data only with no point in flight; not enforced.
module quadratic_bulb_iteration_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  qbis_pkg::in_t    cmd,
	output logic             done,
	output qbis_pkg::out_t   result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_data
);

	logic [8:0]    mode_q;
	logic [31:0]   win_q;
	logic [4:0]    cidx_q;
	qbis_pkg::fx_t coef_q [qbis_pkg::COEF_USED];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 9'd16;
			win_q  <= 32'hff00ff00;
			cidx_q <= '0;
			for (int k = 0; k < qbis_pkg::COEF_USED; k++) coef_q[k] <= qbis_pkg::coef_init(k);
		end else if (cfg_we) begin
			unique case (qbis_pkg::cfg_idx_t'(cfg_idx))
				qbis_pkg::CFG_MODE: begin
					mode_q <= cfg_data[8:0];
				end
				qbis_pkg::CFG_WINDOWS: begin
					win_q <= cfg_data;
				end
				qbis_pkg::CFG_COEF_INDEX: begin
					cidx_q <= cfg_data[4:0];
				end
				qbis_pkg::CFG_COEF_VALUE: begin
					for (int k = 0; k < qbis_pkg::COEF_USED; k++)
						if (cidx_q == 5'(k)) coef_q[k] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// input stage: abs and window flags
	qbis_pkg::pt_t a_d;
	qbis_pkg::pt_t a_s1;
	logic          a_vld_s1;

	always_comb begin
		a_d         = '0;
		a_d.v[0]    = cmd.x_in;
		a_d.v[1]    = cmd.y_in;
		a_d.v[2]    = cmd.z_in;
		a_d.seed[0] = cmd.seed_x;
		a_d.seed[1] = cmd.seed_y;
		a_d.seed[2] = cmd.seed_z;
		a_d.de      = cmd.de_in;
		a_d.ovf     = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (mode_q[qbis_pkg::M_ABS] && mode_q[qbis_pkg::M_ABS_X + i] && a_d.v[i][31]) begin
				a_d.ovf  = a_d.ovf | qbis_pkg::sat_ovf(-66'($signed(a_d.v[i])));
				a_d.v[i] = qbis_pkg::sat_fx(-66'($signed(a_d.v[i])));
			end
		end
		a_d.w1 = mode_q[qbis_pkg::M_WIN1] && (cmd.iteration >= win_q[7:0]) &&
			(cmd.iteration < win_q[15:8]);
		a_d.w2 = mode_q[qbis_pkg::M_WIN2] && (cmd.iteration >= win_q[23:16]) &&
			(cmd.iteration < win_q[31:24]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1 <= 1'b0;
		end else begin
			a_vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_d;
	end

	qbis_pkg::fx_t [2:0] mul1, add1, mul2, add2;
	qbis_pkg::fx_t [8:0] rm;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mul1[k] = coef_q[qbis_pkg::C_BR1 + qbis_pkg::B_MUL + k];
			add1[k] = coef_q[qbis_pkg::C_BR1 + qbis_pkg::B_ADD + k];
			mul2[k] = coef_q[qbis_pkg::C_BR2 + qbis_pkg::B_MUL + k];
			add2[k] = coef_q[qbis_pkg::C_BR2 + qbis_pkg::B_ADD + k];
		end
		for (int k = 0; k < 9; k++) rm[k] = coef_q[qbis_pkg::C_ROT + k];
	end

	logic          b1_vld, b2_vld;
	qbis_pkg::pt_t b1_pt, b2_pt;

	qbis_branch #(.IP(0), .IQ(1), .IA(2), .SECOND(1'b0)) u_br1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (mode_q[qbis_pkg::M_BR1]),
		.off     (coef_q[qbis_pkg::C_BR1 + qbis_pkg::B_OFF]),
		.mul     (mul1),
		.ratio   (coef_q[qbis_pkg::C_BR1 + qbis_pkg::B_RATIO]),
		.addv    (add1),
		.in_vld  (a_vld_s1),
		.in_pt   (a_s1),
		.out_vld (b1_vld),
		.out_pt  (b1_pt)
	);

	qbis_branch #(.IP(2), .IQ(1), .IA(0), .SECOND(1'b1)) u_br2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (mode_q[qbis_pkg::M_BR2]),
		.off     (coef_q[qbis_pkg::C_BR2 + qbis_pkg::B_OFF]),
		.mul     (mul2),
		.ratio   (coef_q[qbis_pkg::C_BR2 + qbis_pkg::B_RATIO]),
		.addv    (add2),
		.in_vld  (b1_vld),
		.in_pt   (b1_pt),
		.out_vld (b2_vld),
		.out_pt  (b2_pt)
	);

	qbis_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.tweak   (mode_q[qbis_pkg::M_TWEAK]),
		.rm      (rm),
		.scale   (coef_q[qbis_pkg::C_DE_SCALE]),
		.offs    (coef_q[qbis_pkg::C_DE_OFFSET]),
		.in_vld  (b2_vld),
		.in_pt   (b2_pt),
		.out_vld (done),
		.res     (result)
	);

	assign busy = 1'b0;

endmodule

// File: hdl/qbis_chk.sv
// Port-level checker of the quadratic bulb iteration step, bound to the top level.
module qbis_chk #(
	parameter int LAT = qbis_pkg::TOTAL_LAT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat produced no result");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without accepted beat");

endmodule

bind quadratic_bulb_iteration_step qbis_chk u_chk (.*);
